FILE: sv/ubot_pkg.sv
// ----------------------------------------------------------------------------
// ubot_pkg
// Shared types and constants of the bulk-only transport sequencer.
// ----------------------------------------------------------------------------
package ubot_pkg;

    localparam int IN_DATA_W  = 168;
    localparam int OUT_DATA_W = 104;

    localparam logic [31:0] MAX_BUF     = 32'd16384;
    localparam logic [6:0]  WRAPPER_LEN = 7'd31;
    localparam logic [31:0] WRAPPER_SIG = 32'h4342_5355;
    localparam logic [4:0]  MAX_CB_LEN  = 5'd16;

    localparam logic [1:0] OP_WRAPPER = 2'd0;
    localparam logic [1:0] OP_DONE    = 2'd1;
    localparam logic [1:0] OP_FAIL    = 2'd2;

    typedef enum logic [2:0] {
        ACT_DATA    = 3'd0,
        ACT_ZEROS   = 3'd1,
        ACT_PADDED  = 3'd2,
        ACT_RECEIVE = 3'd3,
        ACT_DISCARD = 3'd4,
        ACT_STATUS  = 3'd5,
        ACT_STALL   = 3'd6
    } t_action;

    typedef enum logic [1:0] {
        ST_PASSED = 2'd0,
        ST_FAILED = 2'd1,
        ST_PHASE  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        PH_WAIT    = 3'd0,
        PH_WRITING = 3'd1,
        PH_READING = 3'd2,
        PH_STATUS  = 3'd3,
        PH_STALL   = 3'd4
    } t_phase;

    typedef struct packed {
        logic [1:0]  op;
        logic [6:0]  wrapper_length;
        logic [31:0] signature;
        logic [31:0] host_tag;
        logic [31:0] host_length;
        logic [7:0]  flags_byte;
        logic [7:0]  lun_byte;
        logic [7:0]  cb_length_byte;
        logic        command_ok;
        logic        write_ready;
        logic        read_ready;
        logic [31:0] device_length;
    } t_event;

    typedef struct packed {
        t_action     action;
        logic [31:0] length;
        logic        zlp;
        logic [31:0] status_tag;
        logic [31:0] status_residue;
        t_status     status_code;
        logic        last;
    } t_result;

    typedef struct packed {
        t_phase      phase;
        logic [31:0] saved_tag;
        logic [31:0] saved_residue;
        t_status     saved_status;
        logic        stall_allowed;
    } t_state;

endpackage

FILE: sv/usb_bulk_only_transport_sequencer_unit.sv
// ----------------------------------------------------------------------------
// usb_bulk_only_transport_sequencer_unit
// Device-side bulk-only transport sequencer.
//
// Input stream (s_axis): one word per event. tuser is the event kind
// (wrapper received, transfer done, transfer failed); tdata carries the
// decoded command wrapper fields and the protocol layer's answer.
// Output stream (m_axis): one word per action (data, zeros, padded data,
// receive, discard, status wrapper, stall); tlast marks the final word of
// an event. An event yields zero, one or two words.
// max_lun is written through i_cfg_we / i_cfg_wdata, by the user only while idle; the block does not enforce this.
// Flow: an accepted event is held in the input register, evaluated from
// it and written to the output queue, from which its first word is
// offered; one event per cycle is taken while the queue has room for two.
// The input register and a four-word output queue decouple the sides: a
// stalled receiver fills the queue, then s_axis_tready drops.
// Reset (synchronous, i_rst_n low) returns to waiting for a wrapper,
// clears saved tag, residue and status, max_lun and the queue.
// ----------------------------------------------------------------------------
module usb_bulk_only_transport_sequencer_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [3:0]                         i_cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // op
    input  logic [1:0]                         s_axis_tuser,
    // wrapper_length, signature, host_tag, host_length, flags_byte, lun_byte,
    // cb_length_byte, command_ok, write_ready, read_ready, device_length
    input  logic [ubot_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // action
    output logic [2:0]                         m_axis_tuser,
    // length, zlp, status_tag, status_residue, status_code
    output logic [ubot_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tlast
);
    import ubot_pkg::*;

    logic          r_in_valid;
    t_event        r_in;
    t_event        n_in;
    logic [3:0]    r_max_lun;
    t_state        r_state;
    t_state        n_state;
    logic [1:0]    w_count;
    t_result       w_res0;
    t_result       w_res1;
    logic          w_consume;
    logic          w_pop;
    t_result       r_fifo [4];
    logic [1:0]    r_wr_ptr;
    logic [1:0]    r_rd_ptr;
    logic [2:0]    r_fill;
    t_result       w_head;

    assign n_in = '{op:             s_axis_tuser,
                    wrapper_length: s_axis_tdata[6:0],
                    signature:      s_axis_tdata[38:7],
                    host_tag:       s_axis_tdata[70:39],
                    host_length:    s_axis_tdata[102:71],
                    flags_byte:     s_axis_tdata[110:103],
                    lun_byte:       s_axis_tdata[118:111],
                    cb_length_byte: s_axis_tdata[126:119],
                    command_ok:     s_axis_tdata[127],
                    write_ready:    s_axis_tdata[128],
                    read_ready:     s_axis_tdata[129],
                    device_length:  s_axis_tdata[161:130]};

    ubot_decide u_decide (
        .i_event   (r_in),
        .i_state   (r_state),
        .i_max_lun (r_max_lun),
        .o_state   (n_state),
        .o_count   (w_count),
        .o_res0    (w_res0),
        .o_res1    (w_res1)
    );

    assign w_consume     = r_in_valid && (r_fill <= 3'd2);
    assign s_axis_tready = !r_in_valid || w_consume;
    assign w_pop         = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in <= n_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_lun <= '0;
        end else if (i_cfg_we) begin
            r_max_lun <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_WAIT, saved_tag: '0, saved_residue: '0,
                         saved_status: ST_PASSED, stall_allowed: 1'b1};
        end else if (w_consume) begin
            r_state <= n_state;
        end
    end

    // output queue
    always_ff @(posedge i_clk) begin
        if (w_consume && w_count != 2'd0) begin
            r_fifo[r_wr_ptr] <= w_res0;
        end
        if (w_consume && w_count == 2'd2) begin
            r_fifo[r_wr_ptr + 2'd1] <= w_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_consume) begin
                r_wr_ptr <= r_wr_ptr + w_count;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            r_fill <= r_fill + (w_consume ? {1'b0, w_count} : 3'd0)
                             - (w_pop ? 3'd1 : 3'd0);
        end
    end

    assign w_head        = r_fifo[r_rd_ptr];
    assign m_axis_tvalid = (r_fill != 3'd0);
    assign m_axis_tuser  = w_head.action;
    assign m_axis_tlast  = w_head.last;
    assign m_axis_tdata  = {5'd0, w_head.status_code, w_head.status_residue,
                            w_head.status_tag, w_head.zlp, w_head.length};

endmodule

FILE: sv/ubot_decide.sv
// ----------------------------------------------------------------------------
// ubot_decide
// Wrapper checks, thirteen-case resolution and completion handling for one
// event: next transport state and up to two result words.
// ----------------------------------------------------------------------------
module ubot_decide (
    input  ubot_pkg::t_event  i_event,
    input  ubot_pkg::t_state  i_state,
    input  logic [3:0]        i_max_lun,
    output ubot_pkg::t_state  o_state,
    output logic [1:0]        o_count,
    output ubot_pkg::t_result o_res0,
    output ubot_pkg::t_result o_res1
);
    import ubot_pkg::*;

    logic        w_bad;
    logic [31:0] w_hl;
    logic [31:0] w_dl;
    logic        w_wr;
    logic        w_rd;
    t_result     w_zero;

    assign w_hl = i_event.host_length;
    assign w_dl = i_event.device_length;
    assign w_wr = i_event.write_ready;
    assign w_rd = i_event.read_ready;

    assign w_bad = (i_event.wrapper_length != WRAPPER_LEN)
                || (i_event.signature != WRAPPER_SIG)
                || (i_event.lun_byte[7:4] != 4'd0)
                || (i_event.cb_length_byte[7:5] != 3'd0)
                || (i_event.cb_length_byte[4:0] > MAX_CB_LEN)
                || (i_event.lun_byte[3:0] > i_max_lun);

    always_comb begin
        w_zero = '{action: ACT_DATA, status_code: ST_PASSED, default: '0};
        o_state = i_state;
        o_count = 2'd0;
        o_res0  = w_zero;
        o_res1  = w_zero;

        if (i_event.op >= OP_FAIL || i_state.phase == PH_STALL) begin
            o_state.phase = PH_STALL;
            o_res0.action = ACT_STALL;
            o_count       = 2'd1;
        end else if (i_event.op == OP_WRAPPER) begin
            if (i_state.phase == PH_WAIT) begin
                if (w_bad) begin
                    o_state.phase = PH_STALL;
                    o_res0.action = ACT_STALL;
                    o_count       = 2'd1;
                end else begin
                    o_state.saved_tag     = i_event.host_tag;
                    o_state.saved_status  = i_event.command_ok ? ST_PASSED : ST_FAILED;
                    o_state.stall_allowed = 1'b1;
                    if (w_hl == 32'd0) begin
                        o_state.saved_residue = '0;
                        if (w_wr || w_rd) begin
                            o_state.saved_status = ST_PHASE;
                        end
                        o_state.phase = PH_STATUS;
                        o_res0.action = ACT_STATUS;
                        o_count       = 2'd1;
                    end else if (i_event.flags_byte[7]) begin
                        if (!w_wr) begin
                            o_state.saved_residue = w_hl;
                            if (w_rd) begin
                                o_state.saved_status = ST_PHASE;
                            end
                            o_res0.action = ACT_ZEROS;
                            o_res0.length = w_hl;
                            if (w_hl <= MAX_BUF) begin
                                o_state.stall_allowed = 1'b0;
                                o_state.phase         = PH_WRITING;
                                o_count               = 2'd1;
                            end else begin
                                o_state.phase = PH_STATUS;
                                o_res1.action = ACT_STATUS;
                                o_count       = 2'd2;
                            end
                        end else begin
                            o_state.saved_residue = w_hl - w_dl;
                            o_state.phase         = PH_WRITING;
                            o_count               = 2'd1;
                            if (w_dl < w_hl && w_hl < MAX_BUF) begin
                                o_state.stall_allowed = 1'b0;
                                o_res0.action         = ACT_PADDED;
                                o_res0.length         = w_hl;
                            end else if (w_dl == w_hl) begin
                                o_res0.action = ACT_DATA;
                                o_res0.length = w_dl;
                            end else if (w_dl < w_hl) begin
                                o_res0.action = ACT_DATA;
                                o_res0.length = w_dl;
                                o_res0.zlp    = 1'b1;
                            end else begin
                                o_state.saved_status  = ST_PHASE;
                                o_state.saved_residue = '0;
                                o_res0.action         = ACT_DATA;
                                o_res0.length         = w_hl;
                            end
                        end
                    end else if (!w_rd) begin
                        o_state.saved_residue = w_hl;
                        if (w_wr) begin
                            o_state.saved_status = ST_PHASE;
                        end
                        o_res0.action = ACT_DISCARD;
                        o_res0.length = w_hl;
                        o_state.phase = PH_STATUS;
                        o_res1.action = ACT_STATUS;
                        o_count       = 2'd2;
                    end else if (w_dl <= w_hl) begin
                        o_state.saved_residue = w_hl - w_dl;
                        o_state.phase         = PH_READING;
                        o_res0.action         = ACT_RECEIVE;
                        o_res0.length         = w_dl;
                        o_count               = 2'd1;
                    end else begin
                        o_state.saved_residue = w_hl;
                        o_state.saved_status  = ST_PHASE;
                        o_state.phase         = PH_STATUS;
                        o_res0.action         = ACT_STATUS;
                        o_count               = 2'd1;
                    end
                end
            end
        end else begin
            unique case (i_state.phase)
                PH_WRITING: begin
                    o_state.phase = PH_STATUS;
                    if (i_state.saved_residue != 32'd0 && i_state.stall_allowed) begin
                        o_res0.action = ACT_STALL;
                        o_res1.action = ACT_STATUS;
                        o_count       = 2'd2;
                    end else begin
                        o_res0.action = ACT_STATUS;
                        o_count       = 2'd1;
                    end
                end
                PH_READING: begin
                    o_state.phase = PH_STATUS;
                    o_res0.action = ACT_STATUS;
                    o_count       = 2'd1;
                end
                PH_STATUS: begin
                    o_state.phase = PH_WAIT;
                end
                default: begin
                    o_count = 2'd0;
                end
            endcase
        end

        // status words carry the updated saved values
        if (o_res0.action == ACT_STATUS) begin
            o_res0.status_tag     = o_state.saved_tag;
            o_res0.status_residue = o_state.saved_residue;
            o_res0.status_code    = o_state.saved_status;
        end
        if (o_res1.action == ACT_STATUS) begin
            o_res1.status_tag     = o_state.saved_tag;
            o_res1.status_residue = o_state.saved_residue;
            o_res1.status_code    = o_state.saved_status;
        end
        o_res0.last = (o_count == 2'd1);
        o_res1.last = 1'b1;
    end

endmodule

FILE: sim/usb_bulk_only_transport_sequencer_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// usb_bulk_only_transport_sequencer_unit_tb
// Self-checking bench for the bulk-only transport sequencer. A clocked driver
// feeds command wrappers and completion events from a queue, and a predictor
// resolves each accepted event into the expected output words. A clocked
// monitor compares each output word field by field. Traffic is well-formed
// transfers with noise, several max_lun settings, a long receiver hold-off,
// and a closing stretch that forces the permanent stall.
// ----------------------------------------------------------------------------
module usb_bulk_only_transport_sequencer_unit_tb;
    import ubot_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_WORDS   = 75;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef enum int {
        BREAK_LENGTH, BREAK_SIG, BREAK_LUN_RSVD, BREAK_CB_RSVD,
        BREAK_CB_LEN, BREAK_LUN_MAX, BREAK_OP_FAIL, BREAK_OP_UNUSED
    } t_break;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [3:0]            i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // op
    logic [1:0]            s_axis_tuser  = '0;
    // wrapper_length, signature, host_tag, host_length, flags_byte, lun_byte,
    // cb_length_byte, command_ok, write_ready, read_ready, device_length
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // action
    logic [2:0]            m_axis_tuser;
    // length, zlp, status_tag, status_residue, status_code
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    usb_bulk_only_transport_sequencer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    t_event  host_events[$];
    t_result due_words[$];
    int      errors = 0;

    // predictor state
    logic [3:0]  lun_limit = '0;
    t_phase      ph        = PH_WAIT;
    logic [31:0] tag_q     = '0;
    logic [31:0] residue_q = '0;
    t_status     status_q  = ST_PASSED;
    logic        stall_ok  = 1'b1;

    // idling controls, set by the stimulus process
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int hold_req   = 0;

    function automatic int draw_gap(bit on);
        int r;
        r = $urandom_range(0, 99);
        if (!on || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void add_word(t_action act, logic [31:0] len, logic zlp,
                                     logic [31:0] tag, logic [31:0] res, t_status code);
        t_result w;
        w.action         = act;
        w.length         = len;
        w.zlp            = zlp;
        w.status_tag     = tag;
        w.status_residue = res;
        w.status_code    = code;
        w.last           = 1'b0;
        due_words.push_back(w);
    endfunction

    function automatic void send_status();
        add_word(ACT_STATUS, '0, 1'b0, tag_q, residue_q, status_q);
        ph = PH_STATUS;
    endfunction

    function automatic void resolve_event(t_event ev);
        int          n0;
        logic [31:0] hl;
        logic [31:0] dl;
        logic        wr;
        logic        rd;
        logic        bad_cbw;
        n0      = due_words.size();
        hl      = ev.host_length;
        dl      = ev.device_length;
        wr      = ev.write_ready;
        rd      = ev.read_ready;
        bad_cbw = ev.wrapper_length != WRAPPER_LEN || ev.signature != WRAPPER_SIG ||
                  ev.lun_byte[7:4] != 4'd0 || ev.cb_length_byte[7:5] != 3'd0 ||
                  ev.cb_length_byte[4:0] > MAX_CB_LEN || ev.lun_byte[3:0] > lun_limit;

        if (ev.op >= OP_FAIL || ph == PH_STALL ||
            (ev.op == OP_WRAPPER && ph == PH_WAIT && bad_cbw)) begin
            ph = PH_STALL;
            add_word(ACT_STALL, '0, 1'b0, '0, '0, ST_PASSED);
        end else if (ev.op == OP_WRAPPER) begin
            if (ph == PH_WAIT) begin
                tag_q    = ev.host_tag;
                status_q = ev.command_ok ? ST_PASSED : ST_FAILED;
                stall_ok = 1'b1;
                if (hl == 0) begin
                    residue_q = '0;
                    if (wr || rd)
                        status_q = ST_PHASE;
                    send_status();
                end else if (ev.flags_byte[7]) begin
                    if (!wr) begin
                        residue_q = hl;
                        if (rd)
                            status_q = ST_PHASE;
                        add_word(ACT_ZEROS, hl, 1'b0, '0, '0, ST_PASSED);
                        if (hl <= MAX_BUF) begin
                            stall_ok = 1'b0;
                            ph       = PH_WRITING;
                        end else begin
                            send_status();
                        end
                    end else begin
                        residue_q = hl - dl;
                        ph        = PH_WRITING;
                        if (dl < hl && hl < MAX_BUF) begin
                            stall_ok = 1'b0;
                            add_word(ACT_PADDED, hl, 1'b0, '0, '0, ST_PASSED);
                        end else if (dl == hl) begin
                            add_word(ACT_DATA, dl, 1'b0, '0, '0, ST_PASSED);
                        end else if (dl < hl) begin
                            add_word(ACT_DATA, dl, 1'b1, '0, '0, ST_PASSED);
                        end else begin
                            status_q  = ST_PHASE;
                            residue_q = '0;
                            add_word(ACT_DATA, hl, 1'b0, '0, '0, ST_PASSED);
                        end
                    end
                end else if (!rd) begin
                    residue_q = hl;
                    if (wr)
                        status_q = ST_PHASE;
                    add_word(ACT_DISCARD, hl, 1'b0, '0, '0, ST_PASSED);
                    send_status();
                end else if (dl <= hl) begin
                    residue_q = hl - dl;
                    ph        = PH_READING;
                    add_word(ACT_RECEIVE, dl, 1'b0, '0, '0, ST_PASSED);
                end else begin
                    residue_q = hl;
                    status_q  = ST_PHASE;
                    send_status();
                end
            end
        end else begin
            case (ph)
                PH_WRITING: begin
                    if (residue_q != 0 && stall_ok)
                        add_word(ACT_STALL, '0, 1'b0, '0, '0, ST_PASSED);
                    send_status();
                end
                PH_READING: send_status();
                PH_STATUS:  ph = PH_WAIT;
                default: ;
            endcase
        end
        if (due_words.size() > n0)
            due_words[due_words.size() - 1].last = 1'b1;
    endfunction

    // ---------------- stimulus builders ----------------
    function automatic t_event rand_ev(logic [1:0] op);
        t_event ev;
        ev.op             = op;
        ev.wrapper_length = 7'($urandom_range(0, 64));
        ev.signature      = ($urandom_range(0, 3) == 0) ? WRAPPER_SIG : $urandom;
        ev.host_tag       = $urandom;
        ev.host_length    = $urandom;
        ev.flags_byte     = 8'($urandom);
        ev.lun_byte       = 8'($urandom);
        ev.cb_length_byte = 8'($urandom);
        ev.command_ok     = 1'($urandom);
        ev.write_ready    = 1'($urandom);
        ev.read_ready     = 1'($urandom);
        ev.device_length  = $urandom;
        return ev;
    endfunction

    function automatic t_event cbw(logic dir_in, logic [31:0] hl, logic [31:0] dl,
                                   logic wr, logic rd, logic ok);
        t_event ev;
        ev                = rand_ev(OP_WRAPPER);
        ev.wrapper_length = WRAPPER_LEN;
        ev.signature      = WRAPPER_SIG;
        ev.host_length    = hl;
        ev.device_length  = dl;
        ev.flags_byte[7]  = dir_in;
        ev.lun_byte       = {4'd0, 4'($urandom_range(0, lun_limit))};
        ev.cb_length_byte = {3'd0, 5'($urandom_range(0, 16))};
        ev.command_ok     = ok;
        ev.write_ready    = wr;
        ev.read_ready     = rd;
        return ev;
    endfunction

    function automatic t_event rand_cbw();
        logic [31:0] hl;
        logic [31:0] dl;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 8)       hl = '0;
        else if (r < 48) hl = $urandom_range(1, 600);
        else if (r < 68) hl = MAX_BUF - 2 + $urandom_range(0, 4);
        else if (r < 93) hl = $urandom;
        else             hl = '1;
        r = $urandom_range(0, 99);
        if (r < 25)      dl = hl;
        else if (r < 35) dl = '0;
        else if (r < 60) dl = 32'($urandom % (64'(hl) + 64'd1));
        else if (r < 85) dl = hl + $urandom_range(1, 100);
        else             dl = $urandom;
        return cbw(1'($urandom), hl, dl, 1'($urandom), 1'($urandom), 1'($urandom));
    endfunction

    // wrapper, optional ignored garbage wrapper, then completions
    task automatic add_seq(t_event ev, int ncomp, bit garbage);
        host_events.push_back(ev);
        if (garbage)
            host_events.push_back(rand_ev(OP_WRAPPER));
        repeat (ncomp)
            host_events.push_back(rand_ev(OP_DONE));
    endtask

    task automatic set_max_lun(logic [3:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        lun_limit    = v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (host_events.size() != 0 || s_axis_tvalid || due_words.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ---------------- driver ----------------
    t_event cur_ev;
    bit     tx_busy;
    int     tx_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            tx_busy = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                resolve_event(cur_ev);
                tx_busy = 1'b0;
            end
            if (!tx_busy) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (host_events.size() > 0) begin
                    cur_ev        = host_events.pop_front();
                    s_axis_tuser <= cur_ev.op;
                    s_axis_tdata <= {6'd0, cur_ev.device_length, cur_ev.read_ready,
                                     cur_ev.write_ready, cur_ev.command_ok,
                                     cur_ev.cb_length_byte, cur_ev.lun_byte,
                                     cur_ev.flags_byte, cur_ev.host_length,
                                     cur_ev.host_tag, cur_ev.signature,
                                     cur_ev.wrapper_length};
                    tx_busy       = 1'b1;
                    tx_gap        = draw_gap(tx_idle_on);
                end
            end
            s_axis_tvalid <= tx_busy;
        end
    end

    // ---------------- monitor ----------------
    t_result want;
    int      rx_hold   = 0;
    int      rx_gap    = 0;
    int      hold_done = 0;
    bit      rx_ready;

    function automatic void field_check(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (due_words.size() == 0) begin
                    $error("unexpected word: action %0d", m_axis_tuser);
                    errors++;
                end else begin
                    want = due_words.pop_front();
                    field_check("action", 32'(want.action), 32'(m_axis_tuser));
                    field_check("length", want.length, m_axis_tdata[31:0]);
                    field_check("zlp", 32'(want.zlp), 32'(m_axis_tdata[32]));
                    field_check("status_tag", want.status_tag, m_axis_tdata[64:33]);
                    field_check("status_residue", want.status_residue, m_axis_tdata[96:65]);
                    field_check("status_code", 32'(want.status_code),
                                32'(m_axis_tdata[98:97]));
                    field_check("last", 32'(want.last), 32'(m_axis_tlast));
                end
            end
            if (hold_done != hold_req) begin
                hold_done++;
                rx_hold = HOLD_CYCLES;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                rx_ready = 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                rx_ready = 1'b0;
            end else begin
                rx_ready = 1'b1;
                rx_gap   = draw_gap(rx_idle_on);
            end
            m_axis_tready <= rx_ready;
        end
    end

    // ---------------- watchdog ----------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("usb_bulk_only_transport_sequencer_unit verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------- stimulus ----------------
    initial begin
        t_event ev;
        t_break brk;
        int     n;
        logic [6:0] wl;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_max_lun(4'd0);

        // directed: every transfer case once
        host_events.push_back(rand_ev(OP_DONE));             // ignored while waiting
        ev = cbw(1'b0, 32'd0, 32'd5, 1'b1, 1'b0, 1'b0);
        ev.host_tag = '1;
        add_seq(ev, 1, 1'b0);                                // no data, phase error
        add_seq(cbw(1'b1, MAX_BUF, 32'd0, 1'b0, 1'b0, 1'b1), 2, 1'b0);
        add_seq(cbw(1'b1, MAX_BUF + 1, 32'd0, 1'b0, 1'b1, 1'b1), 1, 1'b0);
        add_seq(cbw(1'b1, 32'd100, 32'd40, 1'b1, 1'b0, 1'b1), 2, 1'b0);
        add_seq(cbw(1'b1, 32'd512, 32'd512, 1'b1, 1'b0, 1'b1), 2, 1'b0);
        ev = cbw(1'b1, '1, 32'd0, 1'b1, 1'b0, 1'b1);
        ev.host_tag = '0;
        add_seq(ev, 2, 1'b0);                                // short data, stall on done
        add_seq(cbw(1'b1, 32'd8, '1, 1'b1, 1'b1, 1'b0), 2, 1'b0);
        add_seq(cbw(1'b0, 32'd64, 32'd0, 1'b1, 1'b0, 1'b1), 1, 1'b1);
        add_seq(cbw(1'b0, '1, '1, 1'b0, 1'b1, 1'b1), 2, 1'b0);
        add_seq(cbw(1'b0, 32'd10, 32'd11, 1'b0, 1'b1, 1'b1), 1, 1'b0);
        drain();

        for (int p = 0; p < 5; p++) begin
            case (p)
                0: set_max_lun(4'd15);
                2: set_max_lun(4'd0);
                3: set_max_lun(4'd15);
                default: set_max_lun(4'($urandom_range(1, 14)));
            endcase
            tx_idle_on = (p != 1) && (p != 3);
            rx_idle_on = (p != 3);
            if (p == 1)
                hold_req++;
            n = 0;
            while (n < PHASE_WORDS) begin
                add_seq(rand_cbw(), 2, $urandom_range(0, 6) == 0);
                if ($urandom_range(0, 9) == 0)
                    host_events.push_back(rand_ev(OP_DONE));
                n += 3;
            end
            drain();
        end

        // permanent stall: one broken wrapper, failed transfer or unused event kind, then noise
        set_max_lun(4'($urandom_range(0, 14)));
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        ev  = rand_cbw();
        brk = t_break'($urandom_range(0, 7));
        case (brk)
            BREAK_LENGTH: begin
                do wl = 7'($urandom_range(0, 64)); while (wl == WRAPPER_LEN);
                ev.wrapper_length = wl;
            end
            BREAK_SIG:       ev.signature = ev.signature ^ (32'd1 << $urandom_range(0, 31));
            BREAK_LUN_RSVD:  ev.lun_byte[7:4] = 4'($urandom_range(1, 15));
            BREAK_CB_RSVD:   ev.cb_length_byte[7:5] = 3'($urandom_range(1, 7));
            BREAK_CB_LEN:    ev.cb_length_byte[4:0] = 5'($urandom_range(17, 31));
            BREAK_LUN_MAX:   ev.lun_byte[3:0] = 4'($urandom_range(lun_limit + 1, 15));
            BREAK_OP_FAIL:   ev.op = OP_FAIL;
            default:         ev.op = OP_UNUSED;
        endcase
        host_events.push_back(ev);
        ev = rand_ev(OP_WRAPPER);
        ev.wrapper_length = 7'd64;
        host_events.push_back(ev);
        repeat (30)
            host_events.push_back(rand_ev(2'($urandom_range(0, 3))));
        drain();

        if (errors == 0)
            $display("usb_bulk_only_transport_sequencer_unit verification clean");
        else
            $display("usb_bulk_only_transport_sequencer_unit verification failed");
        $finish;
    end

endmodule

FILE: files.f
sv/ubot_pkg.sv
sv/ubot_decide.sv
sv/usb_bulk_only_transport_sequencer_unit.sv
sim/usb_bulk_only_transport_sequencer_unit_tb.sv
